// ===== rtl/l3d_pkg.sv =====
// shared types and codes of the 3d lut trilinear interpolator
`default_nettype none
package l3d_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int CHAN_W = 16;

    typedef struct packed {
        logic signed [CHAN_W-1:0] blue;
        logic signed [CHAN_W-1:0] green;
        logic signed [CHAN_W-1:0] red;
    } rgb_t;

endpackage
`default_nettype wire

// ===== rtl/l3d_ram.sv =====
// lattice memory copy: one write port, two registered read ports
`default_nettype none
module l3d_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire l3d_pkg::rgb_t wr_data,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output l3d_pkg::rgb_t      rd_data_a,
    output l3d_pkg::rgb_t      rd_data_b
);

    l3d_pkg::rgb_t mem [DEPTH];
    l3d_pkg::rgb_t rd_a_reg;
    l3d_pkg::rgb_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire

// ===== rtl/lut3d_trilinear_interp.sv =====
// top level of the 3d lut with trilinear interpolation
`default_nettype none
// Takes one beat per clock while s_tready is high and returns one result per
// lookup beat; write beats store a lattice entry and return nothing.
// The pipeline is: clamp, scale by grid_size-1, index terms, address sums,
// memory read, then x, y and z lerps of one multiply and one add stage each.
// The lattice is held in four copies, each read at two addresses, so all eight
// corners come out together. Writes reach the memory in program order with
// lookups. The whole pipeline freezes while a result waits on m_tready.
// The lattice contents are undefined until written; there is no clearing pass.
// grid_size may only change while no beat is in flight.
module lut3d_trilinear_interp #(
    parameter int GRID_MAX        = 32,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_address[14:0], entry_red, entry_green, entry_blue, coord_x, coord_y,
    // coord_z, zero fill to 120 bits
    input  wire logic [119:0] s_tdata,
    // opcode
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_red, out_green, out_blue
    output logic [47:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [5:0]   cfg_data
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int CW    = F + 1;
    localparam int EXT   = (F + 2 > 18) ? F + 2 : 18;
    localparam int GW    = $clog2(GRID_MAX + 1);
    localparam int IW    = $clog2(GRID_MAX);
    localparam int DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = CW + GW;
    localparam int DW    = l3d_pkg::CHAN_W + 1;
    localparam int PW    = DW + F + 1;
    localparam logic signed [EXT-1:0] ONE_EXT = EXT'(1) <<< F;
    localparam logic signed [PW-1:0]  HALF    = PW'(1) <<< (F - 1);

    // configuration
    logic [5:0]    grid_reg;
    logic [GW-1:0] gs;
    logic [GW-1:0] gmax;
    logic [AW-1:0] gsq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= 6'd32;
        end
        else if (cfg_valid)
        begin
            grid_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (grid_reg < 6'd2)
        begin
            gs = GW'(2);
        end
        else if (32'(grid_reg) > GRID_MAX)
        begin
            gs = GW'(GRID_MAX);
        end
        else
        begin
            gs = GW'(grid_reg);
        end
        gmax = gs - GW'(1);
    end

    always_ff @(posedge clk)
    begin
        gsq_reg <= AW'(gs) * AW'(gs);
    end

    // pipeline advance
    logic ce;
    logic [11:1] v_reg;
    logic [11:1] v_next;
    logic [5:1]  op_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_comb
    begin
        v_next    = v_reg;
        if (ce)
        begin
            v_next[1] = s_tvalid;
            v_next[5:2] = v_reg[4:1];
            v_next[6] = v_reg[5] && (op_reg[5] == l3d_pkg::OP_LOOKUP);
            v_next[11:7] = v_reg[10:6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // input unpack
    logic [14:0]              in_addr;
    l3d_pkg::rgb_t            in_rgb;
    logic signed [17:0]       in_coord [3];

    assign in_addr         = s_tdata[14:0];
    assign in_rgb.red      = s_tdata[30:15];
    assign in_rgb.green    = s_tdata[46:31];
    assign in_rgb.blue     = s_tdata[62:47];
    assign in_coord[0]     = s_tdata[80:63];
    assign in_coord[1]     = s_tdata[98:81];
    assign in_coord[2]     = s_tdata[116:99];

    // payload registers carried with the beat
    logic [14:0]   waddr_reg [1:4];
    l3d_pkg::rgb_t wdata_reg [1:4];
    logic [CW-1:0] c1_reg  [3];
    logic [IW-1:0] lo2_reg [3];
    logic [IW-1:0] hi2_reg [3];
    logic [F-1:0]  f_reg   [2:9][3];
    logic [AW-1:0] kt3_reg [2];
    logic [AW-1:0] jt3_reg [2];
    logic [IW-1:0] i3_reg  [2];
    logic [AW-1:0] a4_reg  [8];

    logic [CW-1:0] c_clamp [3];
    logic [IW-1:0] lo_next [3];
    logic [IW-1:0] hi_next [3];
    logic [F-1:0]  fr_next [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        logic signed [EXT-1:0] ext;
        logic [RW-1:0]         r;
        logic [GW:0]           idx;

        assign ext = EXT'(in_coord[g]);

        always_comb
        begin
            if (in_coord[g][17])
            begin
                c_clamp[g] = '0;
            end
            else if (ext > ONE_EXT)
            begin
                c_clamp[g] = CW'(ONE_EXT);
            end
            else
            begin
                c_clamp[g] = ext[CW-1:0];
            end
        end

        assign r   = RW'(c1_reg[g]) * RW'(gmax);
        assign idx = r[RW-1:F];

        always_comb
        begin
            if (idx >= (GW + 1)'(gmax))
            begin
                lo_next[g] = gmax[IW-1:0];
                hi_next[g] = gmax[IW-1:0];
                fr_next[g] = '0;
            end
            else
            begin
                lo_next[g] = idx[IW-1:0];
                hi_next[g] = idx[IW-1:0] + IW'(1);
                fr_next[g] = r[F-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op_reg[1]    <= s_tuser[0];
            op_reg[5:2]  <= op_reg[4:1];
            waddr_reg[1] <= in_addr;
            wdata_reg[1] <= in_rgb;
            for (int s = 2; s <= 4; s++)
            begin
                waddr_reg[s] <= waddr_reg[s-1];
                wdata_reg[s] <= wdata_reg[s-1];
            end
            for (int g = 0; g < 3; g++)
            begin
                c1_reg[g]     <= c_clamp[g];
                lo2_reg[g]    <= lo_next[g];
                hi2_reg[g]    <= hi_next[g];
                f_reg[2][g]   <= fr_next[g];
            end
            for (int s = 3; s <= 9; s++)
            begin
                f_reg[s] <= f_reg[s-1];
            end
            kt3_reg[0] <= AW'(lo2_reg[2]) * gsq_reg;
            kt3_reg[1] <= AW'(hi2_reg[2]) * gsq_reg;
            jt3_reg[0] <= AW'(lo2_reg[1]) * AW'(gs);
            jt3_reg[1] <= AW'(hi2_reg[1]) * AW'(gs);
            i3_reg[0]  <= lo2_reg[0];
            i3_reg[1]  <= hi2_reg[0];
            // corner bit 0 picks the upper i, bit 1 upper j, bit 2 upper k
            for (int c = 0; c < 8; c++)
            begin
                a4_reg[c] <= kt3_reg[c[2]] + jt3_reg[c[1]] + AW'(i3_reg[c[0]]);
            end
        end
    end

    // lattice copies, written in stream order at the read stage
    logic          wr_en;
    l3d_pkg::rgb_t corner [8];

    assign wr_en = ce && v_reg[4] && (op_reg[4] == l3d_pkg::OP_WRITE)
                   && (32'(waddr_reg[4]) < DEPTH);

    for (genvar n = 0; n < 4; n++)
    begin : g_ram
        l3d_ram #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_ram (
            .clk       (clk),
            .rd_en     (ce),
            .wr_en     (wr_en),
            .wr_addr   (AW'(waddr_reg[4])),
            .wr_data   (wdata_reg[4]),
            .rd_addr_a (a4_reg[2*n]),
            .rd_addr_b (a4_reg[2*n+1]),
            .rd_data_a (corner[2*n]),
            .rd_data_b (corner[2*n+1])
        );
    end

    // lerp as a + round((b - a) * f / 2^F)
    logic signed [15:0]   ca      [3][8];
    logic signed [15:0]   xa6_reg [3][4];
    logic signed [PW-1:0] xp6_reg [3][4];
    logic signed [15:0]   x7_reg  [3][4];
    logic signed [15:0]   ya8_reg [3][2];
    logic signed [PW-1:0] yp8_reg [3][2];
    logic signed [15:0]   y9_reg  [3][2];
    logic signed [15:0]   za10_reg [3];
    logic signed [PW-1:0] zp10_reg [3];
    logic signed [15:0]   z11_reg  [3];

    for (genvar c = 0; c < 8; c++)
    begin : g_corner
        assign ca[0][c] = corner[c].red;
        assign ca[1][c] = corner[c].green;
        assign ca[2][c] = corner[c].blue;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int p = 0; p < 4; p++)
                begin
                    xa6_reg[ch][p] <= ca[ch][2*p];
                    xp6_reg[ch][p] <= PW'(DW'(ca[ch][2*p+1]) - DW'(ca[ch][2*p]))
                                      * PW'($signed({1'b0, f_reg[5][0]}));
                    x7_reg[ch][p]  <= xa6_reg[ch][p]
                                      + 16'((xp6_reg[ch][p] + HALF) >>> F);
                end
                for (int q = 0; q < 2; q++)
                begin
                    ya8_reg[ch][q] <= x7_reg[ch][2*q];
                    yp8_reg[ch][q] <= PW'(DW'(x7_reg[ch][2*q+1]) - DW'(x7_reg[ch][2*q]))
                                      * PW'($signed({1'b0, f_reg[7][1]}));
                    y9_reg[ch][q]  <= ya8_reg[ch][q]
                                      + 16'((yp8_reg[ch][q] + HALF) >>> F);
                end
                za10_reg[ch] <= y9_reg[ch][0];
                zp10_reg[ch] <= PW'(DW'(y9_reg[ch][1]) - DW'(y9_reg[ch][0]))
                                * PW'($signed({1'b0, f_reg[9][2]}));
                z11_reg[ch]  <= za10_reg[ch] + 16'((zp10_reg[ch] + HALF) >>> F);
            end
        end
    end

    assign m_tvalid = v_reg[11];
    assign m_tdata  = {z11_reg[2], z11_reg[1], z11_reg[0]};

`ifndef SYNTHESIS
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");
    a_pin_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && (lo2_reg[0] == hi2_reg[0])) |-> (f_reg[2][0] == '0))
        else $error("pinned x index with nonzero weight");
    a_hi_step: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> ((hi2_reg[2] == lo2_reg[2]) || (hi2_reg[2] == lo2_reg[2] + IW'(1))))
        else $error("upper z index not next to lower one");
`endif

endmodule
`default_nettype wire
